// ----- sv/imu_va_pkg.sv -----
package imu_va_pkg;

	// Fixed-point formats
	localparam int QUAT_FRAC_BITS  = 30;
	localparam int ACCEL_FRAC_BITS = 14;
	localparam int SCALE_FRAC_BITS = 16;
	localparam int G_TO_MS_Q16     = 642689;

	localparam int NSTAGE = 8;

	// Calibration path widths
	localparam int CAL_W  = 33;
	localparam int GAIN_W = (SCALE_FRAC_BITS + 2 > 17) ? SCALE_FRAC_BITS + 2 : 17;
	localparam int PROD_W = CAL_W + GAIN_W;
	localparam int ACC_W  = 40;
	localparam int E_OFF  = SCALE_FRAC_BITS + ACCEL_FRAC_BITS - 29;

	// Gravity vector: shift applied to the quaternion products
	localparam int VEC_K = 2 * QUAT_FRAC_BITS - 30;

	// m/s^2 conversion split into two partial products
	localparam int G_W    = $clog2(G_TO_MS_Q16 + 1);
	localparam int LO_W   = 23;
	localparam int DOT_W  = 46;
	localparam int FULL_W = G_W + 47;

	typedef enum logic [2:0] {
		CFG_BIAS_X     = 3'd0,
		CFG_BIAS_Y     = 3'd1,
		CFG_BIAS_Z     = 3'd2,
		CFG_SCALE      = 3'd3,
		CFG_BIAS_SHIFT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] bias_x;
		logic signed [15:0] bias_y;
		logic signed [15:0] bias_z;
		logic signed [15:0] scale;
		logic [3:0]         bias_shift;
	} cfg_t;

	typedef logic [NSTAGE-1:0] stage_ld_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		logic signed [31:0] r;
		if (x > 68'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -68'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/imu_va_calib.sv -----
module imu_va_calib
	import imu_va_pkg::*;
(
	input  logic                    clk,
	input  stage_ld_t               ld,
	input  cfg_t                    cfg,
	input  logic signed [15:0]      accel_x,
	input  logic signed [15:0]      accel_y,
	input  logic signed [15:0]      accel_z,
	output logic signed [ACC_W-1:0] acc_s3 [3]
);

	localparam logic signed [63:0] LIM50  = 64'sd1 <<< 50;
	localparam logic signed [63:0] ACCLIM = (64'sd1 <<< 39) - 64'sd1;

	logic [15:0]              raw   [3];
	logic signed [15:0]       bias  [3];
	logic signed [CAL_W-1:0]  cal_d [3];
	logic signed [CAL_W-1:0]  cal_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [3];
	logic signed [GAIN_W-1:0] gain;
	logic signed [6:0]        e_sh;

	function automatic logic signed [ACC_W-1:0] to_q29(input logic signed [PROD_W-1:0] p,
			input logic signed [6:0] e);
		logic signed [63:0] pw;
		logic signed [63:0] t;
		logic [5:0]         amt;
		pw = {{(64-PROD_W){p[PROD_W-1]}}, p};
		if (!e[6]) begin
			amt = e[5:0];
			t = pw >>> amt;
		end else begin
			amt = 6'(-e);
			if (pw > LIM50) begin
				pw = LIM50;
			end else if (pw < -LIM50) begin
				pw = -LIM50;
			end
			t = pw <<< amt;
		end
		if (t > ACCLIM) begin
			t = ACCLIM;
		end else if (t < -ACCLIM) begin
			t = -ACCLIM;
		end
		return t[ACC_W-1:0];
	endfunction

	assign raw[0]  = accel_x;
	assign raw[1]  = accel_y;
	assign raw[2]  = accel_z;
	assign bias[0] = cfg.bias_x;
	assign bias[1] = cfg.bias_y;
	assign bias[2] = cfg.bias_z;

	assign gain = $signed({{(GAIN_W-16){cfg.scale[15]}}, cfg.scale})
		+ (GAIN_W'(1) <<< SCALE_FRAC_BITS);
	assign e_sh = $signed({3'b000, cfg.bias_shift}) + 7'(E_OFF);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cal_d[i] = ($signed({{(CAL_W-16){raw[i][15]}}, raw[i]}) <<< cfg.bias_shift)
				- $signed({{(CAL_W-16){bias[i][15]}}, bias[i]});
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (ld[0]) begin
				cal_s1[i] <= cal_d[i];
			end
			if (ld[1]) begin
				prod_s2[i] <= cal_s1[i] * gain;
			end
			if (ld[2]) begin
				acc_s3[i] <= to_q29(prod_s2[i], e_sh);
			end
		end
	end

endmodule

// ----- sv/imu_va_gvec.sv -----
module imu_va_gvec
	import imu_va_pkg::*;
(
	input  logic               clk,
	input  stage_ld_t          ld,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	output logic signed [31:0] v_s2 [3]
);

	localparam int VEC_R = (VEC_K >= 1) ? VEC_K : 0;
	localparam int VEC_L = (VEC_K < 1) ? -VEC_K : 0;
	localparam logic signed [63:0] LIM40 = 64'sd1 <<< 40;

	// xz, wy, yz, wx, ww, zz
	logic signed [63:0] p_s1 [6];
	logic signed [65:0] t0;
	logic signed [65:0] t1;
	logic signed [65:0] t2;

	function automatic logic signed [65:0] vterm(input logic signed [63:0] p1,
			input logic signed [63:0] p2, input logic sub);
		logic signed [64:0] s;
		logic signed [63:0] h;
		logic signed [65:0] t;
		if (sub) begin
			s = $signed({p1[63], p1}) - $signed({p2[63], p2});
		end else begin
			s = $signed({p1[63], p1}) + $signed({p2[63], p2});
		end
		if (VEC_K >= 1) begin
			t = s;
			t = t >>> VEC_R;
		end else begin
			h = s[64:1];
			if (h > LIM40) begin
				h = LIM40;
			end else if (h < -LIM40) begin
				h = -LIM40;
			end
			t = h;
			t = (t <<< 1) + 66'(s[0]);
			t = t <<< VEC_L;
		end
		return t;
	endfunction

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			p_s1[0] <= quat_x * quat_z;
			p_s1[1] <= quat_w * quat_y;
			p_s1[2] <= quat_y * quat_z;
			p_s1[3] <= quat_w * quat_x;
			p_s1[4] <= quat_w * quat_w;
			p_s1[5] <= quat_z * quat_z;
		end
	end

	always_comb begin
		t0 = vterm(p_s1[0], p_s1[1], 1'b1);
		t1 = vterm(p_s1[2], p_s1[3], 1'b0);
		t2 = vterm(p_s1[4], p_s1[5], 1'b0) - (66'sd1 <<< 29);
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			v_s2[0] <= sat32(t0);
			v_s2[1] <= sat32(t1);
			v_s2[2] <= sat32(t2);
		end
	end

endmodule

// ----- sv/imu_va_dot.sv -----
module imu_va_dot
	import imu_va_pkg::*;
(
	input  logic                    clk,
	input  stage_ld_t               ld,
	input  logic signed [ACC_W-1:0] acc_s3 [3],
	input  logic signed [31:0]      v_s2 [3],
	output logic signed [31:0]      v_s8 [3],
	output logic signed [31:0]      vacc_s8
);

	localparam logic [G_W-1:0]        G_U    = G_W'(G_TO_MS_Q16);
	localparam logic signed [G_W:0]   G_COEF = (G_W + 1)'(G_TO_MS_Q16);

	logic signed [31:0]             v_s3 [3];
	logic signed [31:0]             v_s4 [3];
	logic signed [31:0]             v_s5 [3];
	logic signed [31:0]             v_s6 [3];
	logic signed [31:0]             v_s7 [3];
	logic signed [ACC_W:0]          diff [3];
	logic signed [ACC_W-9:0]        rs_s4 [3];
	logic signed [63:0]             t_s5 [3];
	logic signed [65:0]             sum;
	logic signed [DOT_W-1:0]        dot_s6;
	logic [LO_W+G_W-1:0]            plo_s7;
	logic signed [DOT_W-LO_W+G_W:0] phi_s7;
	logic signed [FULL_W-1:0]       full;
	logic signed [FULL_W-1:0]       q16;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = acc_s3[i] - v_s3[i];
		end
		sum = t_s5[0] + t_s5[1] + t_s5[2];
		full = phi_s7;
		full = (full <<< LO_W) + $signed({{(FULL_W-LO_W-G_W){1'b0}}, plo_s7});
		q16 = full >>> 29;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (ld[2]) begin
				v_s3[i] <= v_s2[i];
			end
			if (ld[3]) begin
				v_s4[i]  <= v_s3[i];
				// floor of residual / 2^9
				rs_s4[i] <= diff[i][ACC_W:9];
			end
			if (ld[4]) begin
				v_s5[i] <= v_s4[i];
				t_s5[i] <= rs_s4[i] * v_s4[i];
			end
			if (ld[5]) begin
				v_s6[i] <= v_s5[i];
			end
			if (ld[6]) begin
				v_s7[i] <= v_s6[i];
			end
			if (ld[7]) begin
				v_s8[i] <= v_s7[i];
			end
		end
		if (ld[5]) begin
			dot_s6 <= sum[65:20];
		end
		if (ld[6]) begin
			plo_s7 <= dot_s6[LO_W-1:0] * G_U;
			phi_s7 <= $signed(dot_s6[DOT_W-1:LO_W]) * G_COEF;
		end
		if (ld[7]) begin
			vacc_s8 <= sat32(q16);
		end
	end

endmodule

// ----- sv/imu_vertical_acceleration.sv -----
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: one IMU sample
// m_*       out        m_tvalid / m_tready    m_tdata: gravity vector and vertical accel
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data: register write
//
// One sample per clock sustained while m_tready stays high; each transaction reaches m_*
// through the eight-stage multiply/shift pipeline.
// Reset clears all stage valid bits and loads the register defaults (bias_shift 7).
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up under an output stall and nothing is dropped or repeated.
module imu_vertical_acceleration
	import imu_va_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// vert_x, vert_y, vert_z, vert_accel
	output logic [127:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cfg_t                    cfg_q;
	logic [NSTAGE-1:0]       vld_q;
	logic [NSTAGE-1:0]       rdy;
	stage_ld_t               ld;
	logic signed [ACC_W-1:0] acc_s3 [3];
	logic signed [31:0]      v_s2 [3];
	logic signed [31:0]      v_s8 [3];
	logic signed [31:0]      vacc_s8;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias_x     <= '0;
			cfg_q.bias_y     <= '0;
			cfg_q.bias_z     <= '0;
			cfg_q.scale      <= '0;
			cfg_q.bias_shift <= 4'd7;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BIAS_X:     cfg_q.bias_x     <= cfg_data;
				CFG_BIAS_Y:     cfg_q.bias_y     <= cfg_data;
				CFG_BIAS_Z:     cfg_q.bias_z     <= cfg_data;
				CFG_SCALE:      cfg_q.scale      <= cfg_data;
				CFG_BIAS_SHIFT: cfg_q.bias_shift <= cfg_data[3:0];
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	always_comb begin
		rdy[NSTAGE-1] = !vld_q[NSTAGE-1] || m_tready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		ld[0] = s_tvalid && rdy[0];
		for (int k = 1; k < NSTAGE; k++) begin
			ld[k] = vld_q[k-1] && rdy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NSTAGE-1];

	imu_va_calib u_calib (
		.clk     (clk),
		.ld      (ld),
		.cfg     (cfg_q),
		.accel_x (s_tdata[15:0]),
		.accel_y (s_tdata[31:16]),
		.accel_z (s_tdata[47:32]),
		.acc_s3  (acc_s3)
	);

	imu_va_gvec u_gvec (
		.clk    (clk),
		.ld     (ld),
		.quat_w (s_tdata[79:48]),
		.quat_x (s_tdata[111:80]),
		.quat_y (s_tdata[143:112]),
		.quat_z (s_tdata[175:144]),
		.v_s2   (v_s2)
	);

	imu_va_dot u_dot (
		.clk     (clk),
		.ld      (ld),
		.acc_s3  (acc_s3),
		.v_s2    (v_s2),
		.v_s8    (v_s8),
		.vacc_s8 (vacc_s8)
	);

	assign m_tdata = {vacc_s8, v_s8[2], v_s8[1], v_s8[0]};

	// With the output stage empty every stage can take data
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// A full pipeline under an output stall must hold off the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !m_tready |-> !s_tready)
		else $error("input accepted into a full stalled pipeline");

	// Output stage gets loaded only from a valid stage before it
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> $past(vld_q[NSTAGE-2]))
		else $error("output valid without a valid source stage");

	a_cfg_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_BIAS_SHIFT
		|=> cfg_q.bias_shift == $past(cfg_data[3:0]))
		else $error("bias_shift write lost");

endmodule

// ----- verif/imu_va_sb_pkg.sv -----
`timescale 1ns / 100ps
package imu_va_sb_pkg;
	import imu_va_pkg::*;

	// s_tdata layout, lowest bits last
	typedef struct packed {
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_w;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
	} imu_sample_t;

	// m_tdata layout, lowest bits last
	typedef struct packed {
		logic signed [31:0] vert_accel;
		logic signed [31:0] vert_z;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_x;
	} vert_result_t;

	localparam longint ACC_CLAMP  = (longint'(1) << 39) - 1;
	localparam longint PROD_CLAMP = longint'(1) << 50;

	class vaccel_scoreboard;
		cfg_t         cal;
		vert_result_t pending_vert[$];
		int           errors;

		function new();
			cal.bias_x     = '0;
			cal.bias_y     = '0;
			cal.bias_z     = '0;
			cal.scale      = '0;
			cal.bias_shift = 4'd7;
			errors         = 0;
		endfunction

		function void set_reg(input logic [2:0] idx, input logic [15:0] data);
			case (idx)
				CFG_BIAS_X: begin
					cal.bias_x = data;
				end
				CFG_BIAS_Y: begin
					cal.bias_y = data;
				end
				CFG_BIAS_Z: begin
					cal.bias_z = data;
				end
				CFG_SCALE: begin
					cal.scale = data;
				end
				CFG_BIAS_SHIFT: begin
					cal.bias_shift = data[3:0];
				end
				default: begin
					// unmapped index: the block drops the write
				end
			endcase
		endfunction

		function longint limit(input longint x, input longint lim);
			if (x > lim) begin
				return lim;
			end
			if (x < -lim) begin
				return -lim;
			end
			return x;
		endfunction

		function logic signed [31:0] clip32(input logic signed [79:0] x);
			if (x > 80'sd2147483647) begin
				return 32'sh7FFF_FFFF;
			end
			if (x < -80'sd2147483648) begin
				return 32'sh8000_0000;
			end
			return x[31:0];
		endfunction

		// raw axis to g in Q29
		function longint calibrate(input logic signed [15:0] raw,
				input logic signed [15:0] bias);
			int     e;
			longint scaled;
			longint prod;
			e = int'(cal.bias_shift) + SCALE_FRAC_BITS + ACCEL_FRAC_BITS - 29;
			scaled = longint'(raw) * (longint'(1) << cal.bias_shift) - longint'(bias);
			prod = scaled * (longint'($signed(cal.scale)) + (longint'(1) << SCALE_FRAC_BITS));
			if (e >= 0) begin
				prod = prod >>> e;
			end else begin
				prod = limit(prod, PROD_CLAMP) * (longint'(1) << -e);
			end
			return limit(prod, ACC_CLAMP);
		endfunction

		function vert_result_t remove_gravity(input imu_sample_t smp);
			logic signed [79:0] qw, qx, qy, qz;
			logic signed [79:0] acc [3];
			logic signed [79:0] v [3];
			logic signed [79:0] sum;
			vert_result_t       res;
			int                 i;
			qw = $signed(smp.quat_w);
			qx = $signed(smp.quat_x);
			qy = $signed(smp.quat_y);
			qz = $signed(smp.quat_z);
			// quaternion products are Q(2*QUAT_FRAC_BITS); doubling folds into the shift
			res.vert_x = clip32((qx * qz - qw * qy) >>> (2 * QUAT_FRAC_BITS - 30));
			res.vert_y = clip32((qy * qz + qw * qx) >>> (2 * QUAT_FRAC_BITS - 30));
			res.vert_z = clip32(((qw * qw + qz * qz) >>> (2 * QUAT_FRAC_BITS - 30))
				- (80'sd1 <<< 29));
			v[0] = $signed(res.vert_x);
			v[1] = $signed(res.vert_y);
			v[2] = $signed(res.vert_z);
			acc[0] = calibrate(smp.accel_x, cal.bias_x);
			acc[1] = calibrate(smp.accel_y, cal.bias_y);
			acc[2] = calibrate(smp.accel_z, cal.bias_z);
			sum = '0;
			for (i = 0; i < 3; i++) begin
				sum += ((acc[i] - v[i]) >>> 9) * v[i];
			end
			sum = sum >>> 20;
			res.vert_accel = clip32((sum * G_TO_MS_Q16) >>> 29);
			return res;
		endfunction

		function void note_sample(input imu_sample_t smp);
			pending_vert.push_back(remove_gravity(smp));
		endfunction

		function int pending();
			return pending_vert.size();
		endfunction

		function void check_vert(input vert_result_t got);
			string        names [4] = '{"vert_x", "vert_y", "vert_z", "vert_accel"};
			vert_result_t want;
			int           i;
			if (pending_vert.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			want = pending_vert.pop_front();
			for (i = 0; i < 4; i++) begin
				if (got[32*i +: 32] !== want[32*i +: 32]) begin
					$error("%s: expected %0d, got %0d", names[i],
						$signed(want[32*i +: 32]), $signed(got[32*i +: 32]));
					errors++;
				end
			end
		endfunction
	endclass

endpackage

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;
	import imu_va_pkg::*;
	import imu_va_sb_pkg::*;

	localparam int PHASE_ITEMS = 102;
	localparam int NUM_PHASES  = 11;
	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 32;
	localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z
	logic [175:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// vert_x, vert_y, vert_z, vert_accel
	logic [127:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	bit               no_idle = 1'b0;
	bit               hold_request = 1'b0;
	int               quiet_cycles = 0;
	vaccel_scoreboard sb;

	imu_vertical_acceleration u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_vert(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("imu_vertical_acceleration: mismatch");
			$finish;
		end
	end

	// result side: ready bursts, random stalls, one long hold on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic send_sample(input imu_sample_t smp);
		s_tdata  <= smp;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(smp);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// hold off the sender until every outstanding result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic load_cfg(input logic [15:0] bx, by, bz, sc, sh);
		write_reg(CFG_BIAS_X, bx);
		write_reg(CFG_BIAS_Y, by);
		write_reg(CFG_BIAS_Z, bz);
		write_reg(CFG_SCALE, sc);
		write_reg(CFG_BIAS_SHIFT, sh);
		cfg_valid <= 1'b0;
	endtask

	function automatic imu_sample_t mk_sample(input logic [15:0] ax, ay, az,
			input logic [31:0] qw, qx, qy, qz);
		imu_sample_t smp;
		smp.accel_x = ax;
		smp.accel_y = ay;
		smp.accel_z = az;
		smp.quat_w  = qw;
		smp.quat_x  = qx;
		smp.quat_y  = qy;
		smp.quat_z  = qz;
		return smp;
	endfunction

	function automatic logic [15:0] pick_cfg_word();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3, 4: return 16'($urandom());
			// around one g
			default: return 16'(int'($urandom_range(0, 40000)) - 20000);
		endcase
	endfunction

	function automatic logic [31:0] pick_qword();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return Q_ONE;
			4: return -Q_ONE;
			default: return $urandom();
		endcase
	endfunction

	function automatic imu_sample_t pick_sample();
		imu_sample_t smp;
		real         c [4];
		real         norm;
		int          i;
		smp.accel_x = pick_axis();
		smp.accel_y = pick_axis();
		smp.accel_z = pick_axis();
		case ($urandom_range(0, 3))
			0, 1: begin
				// unit quaternion in a random direction
				do begin
					norm = 0.0;
					for (i = 0; i < 4; i++) begin
						c[i] = real'($urandom_range(0, 2000000)) / 1.0e6 - 1.0;
						norm += c[i] * c[i];
					end
				end while (norm < 1.0e-4);
				norm = $sqrt(norm);
				smp.quat_w = $rtoi(c[0] / norm * 1073741823.0);
				smp.quat_x = $rtoi(c[1] / norm * 1073741823.0);
				smp.quat_y = $rtoi(c[2] / norm * 1073741823.0);
				smp.quat_z = $rtoi(c[3] / norm * 1073741823.0);
			end
			2: begin
				smp.quat_w = pick_qword();
				smp.quat_x = pick_qword();
				smp.quat_y = pick_qword();
				smp.quat_z = pick_qword();
			end
			default: begin
				smp.quat_w = $urandom();
				smp.quat_x = $urandom();
				smp.quat_y = $urandom();
				smp.quat_z = $urandom();
			end
		endcase
		return smp;
	endfunction

	initial begin
		int phase;
		int n;
		int k;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: level, upside down, rotated, saturating vectors
		send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0));
		send_sample(mk_sample(16'h0000, 16'h0000, 16'sd16384, Q_ONE, 0, 0, 0));
		send_sample(mk_sample(16'h0000, 16'h0000, -16'sd16384, Q_ONE, 0, 0, 0));
		send_sample(mk_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, Q_ONE, 0, 0, 0));
		send_sample(mk_sample(16'h8000, 16'h8000, 16'h8000, Q_ONE, 0, 0, 0));
		send_sample(mk_sample(16'h7FFF, 16'h7FFF, 16'h7FFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_sample(mk_sample(16'h8000, 16'h8000, 16'h8000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_sample(mk_sample(16'h7FFF, 16'h8000, 16'h7FFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(mk_sample(16'h0000, 16'sd16384, 16'h0000, 0, Q_ONE, 0, 0));
		send_sample(mk_sample(16'sd16384, 16'h0000, 16'h0000, 0, 0, Q_ONE, 0));
		send_sample(mk_sample(16'h0000, 16'h0000, 16'sd16384, 0, 0, 0, Q_ONE));
		send_sample(mk_sample(16'h0000, 16'h0000, 16'sd16384, -Q_ONE, 0, 0, 0));
		send_sample(mk_sample(16'sd100, -16'sd200, 16'sd16000,
			32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000));
		send_sample(mk_sample(16'h5555, 16'hAAAA, 16'h5555,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		send_sample(mk_sample(16'hAAAA, 16'h5555, 16'hAAAA,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 0, 0, 0));
		send_sample(mk_sample(16'h7FFF, 16'h7FFF, 16'h7FFF,
			0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
		send_sample(mk_sample(16'h8000, 16'h8000, 16'h8000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(mk_sample(16'hFFFF, 16'h0001, 16'hFFFF,
			32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
		drain();

		// writes to unmapped indexes must leave the calibration alone
		for (k = 1; k <= 3; k++) begin
			write_reg(3'(CFG_BIAS_SHIFT + k), 16'($urandom()));
		end
		cfg_valid <= 1'b0;
		for (n = 0; n < 5; n++) begin
			send_sample(pick_sample());
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			case (phase)
				0: load_cfg(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFF0);
				1: load_cfg(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h000F);
				default: load_cfg(pick_cfg_word(), pick_cfg_word(), pick_cfg_word(),
					pick_cfg_word(), 16'($urandom()));
			endcase
			no_idle = (phase == 5) || (phase == NUM_PHASES - 1);
			// back up the pipeline while the sender keeps offering
			if (phase == 3) begin
				hold_request = 1'b1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_sample(pick_sample());
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("imu_vertical_acceleration: match");
		end else begin
			$display("imu_vertical_acceleration: mismatch");
		end
		$finish;
	end

endmodule
